// File: rtl/i2ceb_pkg.sv
// Shared types, codes and the command plan table for the I2C EEPROM byte master.
// Used by i2ceb_step and i2c_eeprom_byte_master; depends on nothing else.
package i2ceb_pkg;

    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_TIMEOUT    = 8'd1;

    localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'hA0;
    localparam logic [7:0] ACK_TIMEOUT_RESET    = 8'd250;

    localparam logic [1:0] MODE_WRITE       = 2'd0;
    localparam logic [1:0] MODE_RANDOM_READ = 2'd1;
    localparam logic [1:0] MODE_CURR_READ   = 2'd2;
    localparam logic [1:0] MODE_UNUSED      = 2'd3;

    localparam logic [2:0] PLAN_LAST = 3'd6;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    localparam logic [2:0] LEN_START = 3'd4;
    localparam logic [2:0] LEN_BIT   = 3'd2;
    localparam logic [2:0] LEN_STOP  = 3'd4;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_A,
        PH_ST_B,
        PH_TX_LOW,
        PH_TX_HIGH,
        PH_TX_TAIL,
        PH_ACK_LOW,
        PH_ACK_HIGH,
        PH_ACK_POLL,
        PH_RX_LOW,
        PH_RX_HIGH,
        PH_NAK_LOW,
        PH_NAK_HIGH,
        PH_SP_A,
        PH_SP_B
    } phase_t;

    typedef enum logic [2:0] {
        ACT_START,
        ACT_DEV_W,
        ACT_ADDR,
        ACT_DATA,
        ACT_DEV_R,
        ACT_READ,
        ACT_STOP
    } act_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] delay_count;
        logic [3:0] bit_count;
        logic [7:0] shift_byte;
        logic [7:0] ack_wait_count;
        logic [1:0] held_mode;
        logic [2:0] held_page;
        logic [7:0] held_word_addr;
        logic [7:0] held_write_data;
        logic [7:0] received_byte;
        logic       fail_flag;
        logic [2:0] plan_pos;
    } state_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic       status;
        logic [7:0] read_data;
    } result_t;

    // Sequence of bus actions for each command; unused slots repeat the stop.
    function automatic act_t plan_act(logic [1:0] m, logic [2:0] pos);
        act_t a;
        a = ACT_STOP;
        case (m)
            MODE_RANDOM_READ:
            begin
                case (pos)
                    3'd0: a = ACT_START;
                    3'd1: a = ACT_DEV_W;
                    3'd2: a = ACT_ADDR;
                    3'd3: a = ACT_START;
                    3'd4: a = ACT_DEV_R;
                    3'd5: a = ACT_READ;
                    default: a = ACT_STOP;
                endcase
            end
            MODE_CURR_READ:
            begin
                case (pos)
                    3'd0: a = ACT_START;
                    3'd1: a = ACT_DEV_R;
                    3'd2: a = ACT_READ;
                    default: a = ACT_STOP;
                endcase
            end
            default:
            begin
                case (pos)
                    3'd0: a = ACT_START;
                    3'd1: a = ACT_DEV_W;
                    3'd2: a = ACT_ADDR;
                    3'd3: a = ACT_DATA;
                    default: a = ACT_STOP;
                endcase
            end
        endcase
        return a;
    endfunction

    // Sets up the phase for the plan entry at pos.
    function automatic state_t begin_act(state_t s, logic [7:0] dev_base, logic [2:0] pos);
        state_t     r;
        logic [7:0] dev;
        r = s;
        dev = dev_base | {5'd0, s.held_page};
        r.plan_pos = pos;
        r.delay_count = 2'd0;
        case (plan_act(s.held_mode, pos))
            ACT_START: r.phase = PH_ST_A;
            ACT_DEV_W:
            begin
                r.shift_byte = dev;
                r.bit_count = 4'd0;
                r.phase = PH_TX_LOW;
            end
            ACT_ADDR:
            begin
                r.shift_byte = s.held_word_addr;
                r.bit_count = 4'd0;
                r.phase = PH_TX_LOW;
            end
            ACT_DATA:
            begin
                r.shift_byte = s.held_write_data;
                r.bit_count = 4'd0;
                r.phase = PH_TX_LOW;
            end
            ACT_DEV_R:
            begin
                r.shift_byte = dev | 8'd1;
                r.bit_count = 4'd0;
                r.phase = PH_TX_LOW;
            end
            ACT_READ:
            begin
                r.received_byte = 8'd0;
                r.bit_count = 4'd0;
                r.phase = PH_RX_LOW;
            end
            default: r.phase = PH_SP_A;
        endcase
        return r;
    endfunction

    // True when a segment of the given length ends on this tick.
    function automatic logic seg_end(logic [1:0] d, logic [2:0] len);
        return ({1'b0, d} + 3'd1) >= len;
    endfunction

endpackage

// File: rtl/i2ceb_step.sv
// Next-state and bus-level logic for one tick of the I2C EEPROM byte master.
// Uses i2ceb_pkg for the state layout, phases and command plan.
module i2ceb_step (
    input  i2ceb_pkg::state_t  state_cur,
    input  logic [7:0]         device_address,
    input  logic [7:0]         ack_timeout,
    input  logic               start_cmd,
    input  logic [1:0]         mode,
    input  logic [2:0]         page_bits,
    input  logic [7:0]         word_addr,
    input  logic [7:0]         write_data,
    input  logic               sda_in,
    output i2ceb_pkg::state_t  state_next,
    output i2ceb_pkg::result_t result
);

    i2ceb_pkg::state_t s;
    logic              tx_bit;
    logic [2:0]        pos_next;

    assign tx_bit = state_cur.shift_byte[7];

    always_comb
    begin
        s = state_cur;
        result.scl_level = 1'b1;
        result.sda_level = 1'b1;
        result.busy_res = 1'b1;
        result.done_res = 1'b0;
        result.status = 1'b0;
        result.read_data = 8'd0;

        if (s.phase == i2ceb_pkg::PH_IDLE && start_cmd && mode != i2ceb_pkg::MODE_UNUSED)
        begin
            s.held_mode = mode;
            s.held_page = page_bits;
            s.held_word_addr = word_addr;
            s.held_write_data = write_data;
            s.fail_flag = 1'b0;
            s.received_byte = 8'd0;
            s = i2ceb_pkg::begin_act(s, device_address, 3'd0);
        end

        pos_next = (s.plan_pos < i2ceb_pkg::PLAN_LAST) ? s.plan_pos + 3'd1
                                                        : i2ceb_pkg::PLAN_LAST;

        case (s.phase)
            i2ceb_pkg::PH_ST_A:
            begin
                if (i2ceb_pkg::seg_end(s.delay_count, i2ceb_pkg::LEN_START))
                begin
                    s.phase = i2ceb_pkg::PH_ST_B;
                    s.delay_count = 2'd0;
                end
                else
                    s.delay_count = s.delay_count + 2'd1;
            end
            i2ceb_pkg::PH_ST_B:
            begin
                result.sda_level = 1'b0;
                if (i2ceb_pkg::seg_end(s.delay_count, i2ceb_pkg::LEN_START))
                    s = i2ceb_pkg::begin_act(s, device_address, pos_next);
                else
                    s.delay_count = s.delay_count + 2'd1;
            end
            i2ceb_pkg::PH_TX_LOW:
            begin
                result.scl_level = 1'b0;
                result.sda_level = tx_bit;
                if (i2ceb_pkg::seg_end(s.delay_count, i2ceb_pkg::LEN_BIT))
                begin
                    s.phase = i2ceb_pkg::PH_TX_HIGH;
                    s.delay_count = 2'd0;
                end
                else
                    s.delay_count = s.delay_count + 2'd1;
            end
            i2ceb_pkg::PH_TX_HIGH:
            begin
                result.sda_level = tx_bit;
                if (i2ceb_pkg::seg_end(s.delay_count, i2ceb_pkg::LEN_BIT))
                begin
                    s.phase = i2ceb_pkg::PH_TX_TAIL;
                    s.delay_count = 2'd0;
                end
                else
                    s.delay_count = s.delay_count + 2'd1;
            end
            i2ceb_pkg::PH_TX_TAIL:
            begin
                result.scl_level = 1'b0;
                result.sda_level = tx_bit;
                if (i2ceb_pkg::seg_end(s.delay_count, i2ceb_pkg::LEN_BIT))
                begin
                    s.shift_byte = {s.shift_byte[6:0], 1'b0};
                    s.bit_count = s.bit_count + 4'd1;
                    s.delay_count = 2'd0;
                    if (s.bit_count >= i2ceb_pkg::BITS_PER_BYTE)
                    begin
                        s.ack_wait_count = 8'd0;
                        s.phase = i2ceb_pkg::PH_ACK_LOW;
                    end
                    else
                        s.phase = i2ceb_pkg::PH_TX_LOW;
                end
                else
                    s.delay_count = s.delay_count + 2'd1;
            end
            i2ceb_pkg::PH_ACK_LOW:
            begin
                result.scl_level = 1'b0;
                s.phase = i2ceb_pkg::PH_ACK_HIGH;
                s.delay_count = 2'd0;
            end
            i2ceb_pkg::PH_ACK_HIGH:
            begin
                s.phase = i2ceb_pkg::PH_ACK_POLL;
                s.delay_count = 2'd0;
            end
            i2ceb_pkg::PH_ACK_POLL:
            begin
                if (!sda_in)
                    s = i2ceb_pkg::begin_act(s, device_address, pos_next);
                else if (s.ack_wait_count >= ack_timeout)
                begin
                    // No acknowledge in time: abort straight into the stop.
                    s.fail_flag = 1'b1;
                    s.phase = i2ceb_pkg::PH_SP_A;
                    s.delay_count = 2'd0;
                end
                else
                    s.ack_wait_count = s.ack_wait_count + 8'd1;
            end
            i2ceb_pkg::PH_RX_LOW:
            begin
                result.scl_level = 1'b0;
                if (i2ceb_pkg::seg_end(s.delay_count, i2ceb_pkg::LEN_BIT))
                begin
                    s.phase = i2ceb_pkg::PH_RX_HIGH;
                    s.delay_count = 2'd0;
                end
                else
                    s.delay_count = s.delay_count + 2'd1;
            end
            i2ceb_pkg::PH_RX_HIGH:
            begin
                s.received_byte = {s.received_byte[6:0], sda_in};
                s.bit_count = s.bit_count + 4'd1;
                s.delay_count = 2'd0;
                s.phase = (s.bit_count >= i2ceb_pkg::BITS_PER_BYTE) ? i2ceb_pkg::PH_NAK_LOW
                                                                   : i2ceb_pkg::PH_RX_LOW;
            end
            i2ceb_pkg::PH_NAK_LOW:
            begin
                result.scl_level = 1'b0;
                if (i2ceb_pkg::seg_end(s.delay_count, i2ceb_pkg::LEN_BIT))
                begin
                    s.phase = i2ceb_pkg::PH_NAK_HIGH;
                    s.delay_count = 2'd0;
                end
                else
                    s.delay_count = s.delay_count + 2'd1;
            end
            i2ceb_pkg::PH_NAK_HIGH:
            begin
                if (i2ceb_pkg::seg_end(s.delay_count, i2ceb_pkg::LEN_BIT))
                    s = i2ceb_pkg::begin_act(s, device_address, pos_next);
                else
                    s.delay_count = s.delay_count + 2'd1;
            end
            i2ceb_pkg::PH_SP_A:
            begin
                result.scl_level = 1'b0;
                result.sda_level = 1'b0;
                if (i2ceb_pkg::seg_end(s.delay_count, i2ceb_pkg::LEN_STOP))
                begin
                    s.phase = i2ceb_pkg::PH_SP_B;
                    s.delay_count = 2'd0;
                end
                else
                    s.delay_count = s.delay_count + 2'd1;
            end
            i2ceb_pkg::PH_SP_B:
            begin
                if (i2ceb_pkg::seg_end(s.delay_count, i2ceb_pkg::LEN_STOP))
                begin
                    result.done_res = 1'b1;
                    result.status = s.fail_flag;
                    result.read_data = (s.fail_flag || s.held_mode == i2ceb_pkg::MODE_WRITE)
                                       ? 8'd0 : s.received_byte;
                    s.phase = i2ceb_pkg::PH_IDLE;
                    s.delay_count = 2'd0;
                end
                else
                    s.delay_count = s.delay_count + 2'd1;
            end
            default:
            begin
                s.phase = i2ceb_pkg::PH_IDLE;
                result.busy_res = 1'b0;
            end
        endcase
        state_next = s;
    end

endmodule

// File: rtl/i2c_eeprom_byte_master.sv
// I2C EEPROM byte master, one bus tick per input beat, one result beat per tick.
// Latency: a result beat is valid the cycle after its input beat is accepted.
// Throughput: one tick per cycle, set by the single state register update per beat;
// a new beat is taken while the result register drains (out_ready high).
// Reset (rst_n low, asynchronous) returns the master to idle, clears the result
// register and loads device_address 0xA0 and ack_timeout 250. Depends on i2ceb_pkg, i2ceb_step.
module i2c_eeprom_byte_master (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             start_cmd,
    input  logic [1:0]                       mode,
    input  logic [2:0]                       page_bits,
    input  logic [7:0]                       word_addr,
    input  logic [7:0]                       write_data,
    input  logic                             sda_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             scl_level,
    output logic                             sda_level,
    output logic                             busy_res,
    output logic                             done_res,
    output logic                             status,
    output logic [7:0]                       read_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [i2ceb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data
);

    i2ceb_pkg::state_t  state_reg;
    i2ceb_pkg::state_t  state_next;
    i2ceb_pkg::result_t result_reg;
    i2ceb_pkg::result_t result_next;
    logic               out_valid_reg;
    logic [7:0]         device_address_reg;
    logic [7:0]         ack_timeout_reg;
    logic               in_beat;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_beat = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    i2ceb_step u_step (
        .state_cur      (state_reg),
        .device_address (device_address_reg),
        .ack_timeout    (ack_timeout_reg),
        .start_cmd      (start_cmd),
        .mode           (mode),
        .page_bits      (page_bits),
        .word_addr      (word_addr),
        .write_data     (write_data),
        .sda_in         (sda_in),
        .state_next     (state_next),
        .result         (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                state_reg <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_reg <= '0;
        else if (in_beat)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= i2ceb_pkg::DEVICE_ADDRESS_RESET;
            ack_timeout_reg <= i2ceb_pkg::ACK_TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                i2ceb_pkg::REG_DEVICE_ADDRESS: device_address_reg <= cfg_data;
                i2ceb_pkg::REG_ACK_TIMEOUT:    ack_timeout_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_level = result_reg.scl_level;
    assign sda_level = result_reg.sda_level;
    assign busy_res = result_reg.busy_res;
    assign done_res = result_reg.done_res;
    assign status = result_reg.status;
    assign read_data = result_reg.read_data;

endmodule
